[hdl/assert_macros.svh]
// Assertion macros for the checker file of the affine transform engine.
// Each macro samples on clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/afe_pkg.sv]
// Package for the affine transform engine: field widths, command and axis codes.
// No dependencies; used by the engine, its checker and the testbench.
`default_nettype none

package afe_pkg;

  localparam int DATA_W  = 32;
  localparam int ANGLE_W = 13;
  localparam int KIND_W  = 2;
  localparam int AXIS_W  = 2;

  typedef logic signed [DATA_W-1:0] coord_t;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  localparam real PI = 3.141592653589793;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENTITY  = 2'd0,
    KIND_ROTATE    = 2'd1,
    KIND_TRANSLATE = 2'd2,
    KIND_POINT     = 2'd3
  } kind_t;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

endpackage

`default_nettype wire

[hdl/affine_transform_engine.sv]
// Affine transform engine: 3x4 Q-format matrix with rotate, translate and point transform.
// Depends on afe_pkg.
`default_nettype none
//
//  channel   direction  handshake             payload
//  --------  ---------  --------------------  ------------------------------------------
//  command   in         cmd_valid / cmd_stall  kind, axis_select, angle, coord_x/y/z
//  result    out        res_valid / res_stall  out_x, out_y, out_z (point commands only)
//
//  One command per cycle is taken unless stalled. A transfer loads the command and its
//  sine ROM reads into the stage register; from there one multiply/add/saturate pass goes
//  into the matrix or, for a point command, into the result register.
//  Unless stalled, throughput is one pass per cycle; the matrix is ready for the next command.
//  Reset loads the identity matrix, empties both stages and stalls commands.
//  A point command waits in the stage register only while an earlier result is stalled.

module affine_transform_engine #(
  parameter int FRAC_BITS        = 16,
  parameter int STEPS_PER_DEGREE = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [afe_pkg::KIND_W-1:0]          kind,
  input  logic [afe_pkg::AXIS_W-1:0]          axis_select,
  input  logic [afe_pkg::ANGLE_W-1:0]         angle,
  input  logic signed [afe_pkg::DATA_W-1:0]   coord_x,
  input  logic signed [afe_pkg::DATA_W-1:0]   coord_y,
  input  logic signed [afe_pkg::DATA_W-1:0]   coord_z,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [afe_pkg::DATA_W-1:0]   out_x,
  output logic signed [afe_pkg::DATA_W-1:0]   out_y,
  output logic signed [afe_pkg::DATA_W-1:0]   out_z
);
  import afe_pkg::*;

  // Angle geometry: one quarter turn in angle steps, and the full turn.
  localparam int QTR       = 90 * STEPS_PER_DEGREE;
  localparam int FULL      = 4 * QTR;
  localparam int AR_W      = $clog2(FULL);
  localparam int RED_W     = (ANGLE_W > AR_W) ? ANGLE_W : AR_W;
  localparam int RED_STEPS = $clog2((2 ** ANGLE_W + FULL - 1) / FULL);
  localparam int QA_W      = $clog2(QTR + 1);

  // Radians per angle step.
  localparam real ANG_STEP = PI / (180.0 * real'(STEPS_PER_DEGREE));

  // Coefficient and accumulator widths.
  localparam int ROM_W  = FRAC_BITS + 1;
  localparam int COEF_W = FRAC_BITS + 2;
  localparam int PROD_W = 2 * DATA_W;
  localparam int OPR_W  = DATA_W + COEF_W;
  localparam int ACC_W  = PROD_W - FRAC_BITS + 2;

  localparam coord_t ONE = coord_t'(2 ** FRAC_BITS);

  typedef coord_t mat_t [12];
  localparam mat_t IDENT = '{ONE, '0, '0, '0,
                             '0, ONE, '0, '0,
                             '0, '0, ONE, '0};

  // Quarter-wave sine table, entries 0..QTR, rounded to nearest.
  typedef logic [ROM_W-1:0] rom_t [QTR+1];

  function automatic rom_t build_rom();
    rom_t tbl;
    real  ang;
    real  val;
    for (int i = 0; i <= QTR; i++) begin
      ang    = ANG_STEP * real'(i);
      val    = $sin(ang) * (2.0 ** FRAC_BITS);
      tbl[i] = ROM_W'($rtoi(val + 0.5));
    end
    return tbl;
  endfunction

  localparam rom_t SIN_ROM = build_rom();

  function automatic coord_t sat(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(COORD_MAX)) return COORD_MAX;
    if (v < ACC_W'(COORD_MIN)) return COORD_MIN;
    return v[DATA_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic  s1_valid;
  kind_t s1_kind;
  logic  out_free;
  logic  s1_fire;
  logic  cmd_xfer;

  // The result register is free when empty or being drained this cycle.
  assign out_free  = !res_valid || !res_stall;
  // Only a point command needs the result register; others retire at once.
  assign s1_fire   = s1_valid && ((s1_kind != KIND_POINT) || out_free);
  // Hold off commands during reset so none is dropped.
  assign cmd_stall = rst || (s1_valid && !s1_fire);
  assign cmd_xfer  = cmd_valid && !cmd_stall;

  // ---------------------------------------------------------------------------
  // Stage 0: fold angle into quadrant and offset, form both ROM addresses
  // ---------------------------------------------------------------------------
  logic [RED_W-1:0] ang_red;
  logic [AR_W-1:0]  ang_mod;
  logic [AR_W-1:0]  ang_rem;
  quad_t            quad_in;
  logic [QA_W-1:0]  sin_addr;
  logic [QA_W-1:0]  cos_addr;

  always_comb begin
    ang_red = RED_W'(angle);
    // Conditional subtraction of the full turn times powers of two, largest first.
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (ang_red >= RED_W'(FULL * (2 ** k))) begin
        ang_red = ang_red - RED_W'(FULL * (2 ** k));
      end
    end
    ang_mod = ang_red[AR_W-1:0];
    if (ang_mod >= AR_W'(3 * QTR)) begin
      quad_in = QUAD_3;
      ang_rem = ang_mod - AR_W'(3 * QTR);
    end else if (ang_mod >= AR_W'(2 * QTR)) begin
      quad_in = QUAD_2;
      ang_rem = ang_mod - AR_W'(2 * QTR);
    end else if (ang_mod >= AR_W'(QTR)) begin
      quad_in = QUAD_1;
      ang_rem = ang_mod - AR_W'(QTR);
    end else begin
      quad_in = QUAD_0;
      ang_rem = ang_mod;
    end
    sin_addr = ang_rem[QA_W-1:0];
    // Cosine of the offset is the sine of its complement within the quarter.
    cos_addr = QA_W'(QTR) - sin_addr;
  end

  // ---------------------------------------------------------------------------
  // Stage register: command fields plus registered ROM reads
  // ---------------------------------------------------------------------------
  axis_t            s1_axis;
  quad_t            s1_quad;
  logic [ROM_W-1:0] s1_rom_s;
  logic [ROM_W-1:0] s1_rom_c;
  coord_t           s1_v [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_xfer || (s1_valid && !s1_fire);
    end
    if (cmd_xfer) begin
      s1_kind  <= kind_t'(kind);
      s1_axis  <= axis_t'(axis_select);
      s1_quad  <= quad_in;
      s1_rom_s <= SIN_ROM[sin_addr];
      s1_rom_c <= SIN_ROM[cos_addr];
      s1_v[0]  <= coord_x;
      s1_v[1]  <= coord_y;
      s1_v[2]  <= coord_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: signed sine/cosine, rotation plane, products and sums
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] rs;
  logic signed [COEF_W-1:0] rc;
  logic signed [COEF_W-1:0] sn;
  logic signed [COEF_W-1:0] cs;

  assign rs = signed'(COEF_W'(s1_rom_s));
  assign rc = signed'(COEF_W'(s1_rom_c));

  always_comb begin
    case (s1_quad)
      QUAD_0: begin
        sn = rs;
        cs = rc;
      end
      QUAD_1: begin
        sn = rc;
        cs = -rs;
      end
      QUAD_2: begin
        sn = -rs;
        cs = -rc;
      end
      default: begin
        sn = -rc;
        cs = rs;
      end
    endcase
  end

  // plane_lead: row takes +sine from the next row; plane_trail: -sine from the one before.
  logic [2:0] plane_lead;
  logic [2:0] plane_trail;

  always_comb begin
    plane_lead = '0;
    case (s1_axis)
      AXIS_X:  plane_lead[1] = 1'b1;
      AXIS_Y:  plane_lead[2] = 1'b1;
      AXIS_Z:  plane_lead[0] = 1'b1;
      default: plane_lead = '0;
    endcase
  end

  assign plane_trail = {plane_lead[1], plane_lead[0], plane_lead[2]};

  mat_t mat;
  mat_t mat_next;

  coord_t                   self_op    [3][4];
  logic signed [PROD_W-1:0] self_prod  [3][4];
  logic signed [COEF_W-1:0] other_coef [3][4];
  coord_t                   other_row  [3][4];
  logic signed [OPR_W-1:0]  other_prod [3][4];
  logic signed [ACC_W-1:0]  self_q     [3][4];
  logic signed [ACC_W-1:0]  rot_sum    [3][4];
  logic signed [ACC_W-1:0]  pt_sum     [3];
  logic signed [ACC_W-1:0]  tr_sum     [3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    // Neighbor rows in the cyclic order x, y, z.
    localparam int NXT = (i + 1) % 3;
    localparam int PRV = (i + 2) % 3;
    for (genvar j = 0; j < 4; j++) begin : g_col
      // The self-row multiplier doubles as the point multiplier on columns 0..2.
      if (j < 3) begin : g_shared
        assign self_op[i][j] = (s1_kind == KIND_POINT) ? s1_v[j] : DATA_W'(cs);
      end else begin : g_offset
        assign self_op[i][j] = DATA_W'(cs);
      end
      assign self_prod[i][j]  = self_op[i][j] * mat[i*4+j];
      assign other_row[i][j]  = plane_lead[i] ? mat[NXT * 4 + j]
                                              : mat[PRV * 4 + j];
      assign other_coef[i][j] = plane_lead[i] ? sn : -sn;
      assign other_prod[i][j] = other_coef[i][j] * other_row[i][j];
      // Arithmetic shift rounds toward minus infinity.
      assign self_q[i][j]     = ACC_W'(self_prod[i][j] >>> FRAC_BITS);
      assign rot_sum[i][j]    = self_q[i][j] + ACC_W'(other_prod[i][j] >>> FRAC_BITS);
    end
    assign pt_sum[i] = ACC_W'(mat[i*4+3]) + self_q[i][0] + self_q[i][1] + self_q[i][2];
    assign tr_sum[i] = ACC_W'(mat[i*4+3]) + ACC_W'(s1_v[i]);
  end

  always_comb begin
    mat_next = mat;
    case (s1_kind)
      KIND_IDENTITY: begin
        mat_next = IDENT;
      end
      KIND_ROTATE: begin
        // Rows outside the rotation plane pass through unchanged.
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 4; j++) begin
            if (plane_lead[i] || plane_trail[i]) begin
              mat_next[i*4+j] = sat(rot_sum[i][j]);
            end
          end
        end
      end
      KIND_TRANSLATE: begin
        // Premultiplying by a translation only moves the offset column.
        for (int i = 0; i < 3; i++) begin
          mat_next[i*4+3] = sat(tr_sum[i]);
        end
      end
      default: begin
        mat_next = mat;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Matrix and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= IDENT;
    end else if (s1_fire) begin
      mat <= mat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && (s1_kind == KIND_POINT)) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (s1_fire && (s1_kind == KIND_POINT)) begin
      out_x <= sat(pt_sum[0]);
      out_y <= sat(pt_sum[1]);
      out_z <= sat(pt_sum[2]);
    end
  end

endmodule

`default_nettype wire

[hdl/afe_checker.sv]
// Port-level checker for the affine transform engine, bound into the engine module.
// Depends on afe_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module afe_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              cmd_valid,
  input wire logic                              cmd_stall,
  input wire logic [afe_pkg::KIND_W-1:0]        kind,
  input wire logic                              res_valid,
  input wire logic                              res_stall,
  input wire logic signed [afe_pkg::DATA_W-1:0] out_x,
  input wire logic signed [afe_pkg::DATA_W-1:0] out_y,
  input wire logic signed [afe_pkg::DATA_W-1:0] out_z
);
  import afe_pkg::*;

  // Reset drops any pending result.
  `AFE_ASSERT_NOW(a_reset_clears, $past(rst), !res_valid, "result valid right after reset")

  // Commands back up only behind a stalled result.
  `AFE_ASSERT_NOW(a_stall_cause, cmd_stall, res_valid && res_stall, "command stall without result stall")

  // A fresh result comes from an earlier point command transfer.
  `AFE_ASSERT_NOW(a_result_origin, $rose(res_valid), $past(cmd_valid && !cmd_stall && (kind == KIND_POINT), 2), "result without point command")

  // Hold a stalled result.
  `AFE_ASSERT_NEXT(a_result_hold, res_valid && res_stall, res_valid && $stable(out_x) && $stable(out_y) && $stable(out_z), "stalled result changed")

endmodule

bind affine_transform_engine afe_checker u_afe_checker (.*);

`default_nettype wire

[tb/affine_transform_engine_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for affine_transform_engine: directed table, then random commands.
// Keeps its own copy of the matrix and sine table to predict every point result.
// Depends on afe_pkg and the engine RTL only.

module affine_transform_engine_test;
  import afe_pkg::*;

  localparam int     FRAC         = 16;
  localparam int     STEPS        = 16;
  localparam int     QUARTER      = 90 * STEPS;
  localparam int     TURN         = 4 * QUARTER;
  localparam coord_t ONE          = 32'sh0001_0000;
  localparam int     RANDOM_ITEMS = 1500;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_CYCLES = 12;
  localparam int     CYCLE_LIMIT  = 200_000;
  localparam int     REPORT_LIMIT = 10;

  // pi in unsigned Q2.62, the base of the sine table
  localparam bit [63:0] PI_Q62  = 64'd14488038916154245685;
  localparam bit [63:0] Q62_ONE = 64'd1 << 62;

  typedef struct packed {
    kind_t              kind;
    axis_t              axis;
    logic [ANGLE_W-1:0] angle;
    coord_t             x, y, z;
  } cmd_t;

  typedef struct packed {
    coord_t x, y, z;
  } point_t;

  // One row of the directed table; ex/ey/ez count only when typed is set.
  typedef struct packed {
    kind_t              kind;
    axis_t              axis;
    logic [ANGLE_W-1:0] angle;
    coord_t             x, y, z;
    bit                 typed;
    coord_t             ex, ey, ez;
  } row_t;

  localparam row_t DIRECTED [25] = '{
    // fresh out of reset the matrix is identity: points come back as given
    '{KIND_POINT, AXIS_NONE, 0, 0, 0, 0, 1'b1, 0, 0, 0},
    '{KIND_POINT, AXIS_NONE, 0, COORD_MAX, COORD_MIN, 1, 1'b1, COORD_MAX, COORD_MIN, 1},
    '{KIND_POINT, AXIS_Z, 8191, -1, 32'sh1234_5678, -ONE, 1'b1, -1, 32'sh1234_5678, -ONE},
    // a rotation with no axis leaves the matrix alone
    '{KIND_ROTATE, AXIS_NONE, 1234, 0, 0, 0, 1'b0, 0, 0, 0},
    '{KIND_POINT, AXIS_NONE, 0, ONE, 2 * ONE, 3 * ONE, 1'b1, ONE, 2 * ONE, 3 * ONE},
    // full-scale offset, then points that clip high and cancel to -1
    '{KIND_TRANSLATE, AXIS_NONE, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 0, 0, 0},
    '{KIND_POINT, AXIS_NONE, 0, COORD_MAX, 0, COORD_MIN, 1'b1, COORD_MAX, COORD_MAX, -1},
    '{KIND_POINT, AXIS_NONE, 0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, -1, -1, -1},
    '{KIND_IDENTITY, AXIS_Y, 5759, 32'sh5A5A_5A5A, 32'sh5A5A_5A5A, 32'sh5A5A_5A5A,
      1'b0, 0, 0, 0},
    // two negative full-scale offsets clip the translation column low
    '{KIND_TRANSLATE, AXIS_NONE, 0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 0, 0, 0},
    '{KIND_TRANSLATE, AXIS_NONE, 0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 0, 0, 0},
    '{KIND_POINT, AXIS_NONE, 0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1,
      COORD_MIN, COORD_MIN, COORD_MIN},
    '{KIND_IDENTITY, AXIS_NONE, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    // rotations on every axis, quadrant boundaries and angles past a full turn
    '{KIND_ROTATE, AXIS_Z, 1440, 0, 0, 0, 1'b0, 0, 0, 0},
    '{KIND_POINT, AXIS_NONE, 0, ONE, 2 * ONE, 3 * ONE, 1'b0, 0, 0, 0},
    '{KIND_ROTATE, AXIS_X, 8191, 0, 0, 0, 1'b0, 0, 0, 0},
    '{KIND_ROTATE, AXIS_Y, 5759, 0, 0, 0, 1'b0, 0, 0, 0},
    '{KIND_ROTATE, AXIS_Y, 5760, 0, 0, 0, 1'b0, 0, 0, 0},
    '{KIND_TRANSLATE, AXIS_NONE, 0, 1, -1, COORD_MAX, 1'b0, 0, 0, 0},
    '{KIND_POINT, AXIS_NONE, 0, -1, -1, -1, 1'b0, 0, 0, 0},
    '{KIND_POINT, AXIS_NONE, 0, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 0, 0, 0},
    '{KIND_ROTATE, AXIS_Z, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{KIND_ROTATE, AXIS_X, 2880, 0, 0, 0, 1'b0, 0, 0, 0},
    '{KIND_IDENTITY, AXIS_NONE, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{KIND_POINT, AXIS_NONE, 0, 32'sh0003_8000, -32'sh0001_4000, 32'sh7FFF_0000, 1'b1,
      32'sh0003_8000, -32'sh0001_4000, 32'sh7FFF_0000}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cmd_valid = 1'b0;
  logic                      cmd_stall;
  logic [KIND_W-1:0]         kind = '0;
  logic [AXIS_W-1:0]         axis_select = '0;
  logic [ANGLE_W-1:0]        angle = '0;
  logic signed [DATA_W-1:0]  coord_x = '0;
  logic signed [DATA_W-1:0]  coord_y = '0;
  logic signed [DATA_W-1:0]  coord_z = '0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic signed [DATA_W-1:0]  out_x;
  logic signed [DATA_W-1:0]  out_y;
  logic signed [DATA_W-1:0]  out_z;

  // Shared run controls: bursty turns on random idling on both sides,
  // hold_request asks the receiver for one long hold-off.
  bit     bursty = 1'b1;
  bit     hold_request = 1'b0;
  int     mismatch_count = 0;
  int     cycle_count = 0;

  coord_t model_mat [12];
  longint sin_rom [QUARTER];
  longint cos_rom [QUARTER];
  point_t awaited_points [$];

  affine_transform_engine #(
    .FRAC_BITS        (FRAC),
    .STEPS_PER_DEGREE (STEPS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .kind        (kind),
    .axis_select (axis_select),
    .angle       (angle),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Arithmetic of the engine
  // ---------------------------------------------------------------------------

  // (a * b) >> 62 on unsigned Q2.62, kept exact through a 128-bit product
  function automatic bit [63:0] q62_mul(input bit [63:0] a, input bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Q product, floored: an arithmetic shift rounds toward minus infinity
  function automatic longint qprod(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> FRAC;
  endfunction

  function automatic coord_t clip32(input longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // Apply one accepted command to the model matrix. Return 1 and the
  // transformed point for a point command, 0 for everything else.
  function automatic bit apply_command(input cmd_t c, output point_t p);
    longint stp [12];
    longint v [3];
    coord_t nm [12];
    coord_t res [3];
    longint acc, sn, cs;
    int     a, r, m1, m2;
    p = '0;
    v[0] = c.x;
    v[1] = c.y;
    v[2] = c.z;
    case (c.kind)
      KIND_IDENTITY: begin
        foreach (model_mat[i]) model_mat[i] = (i % 5 == 0) ? ONE : '0;
        return 1'b0;
      end
      KIND_POINT: begin
        for (int i = 0; i < 3; i++) begin
          acc = model_mat[i * 4 + 3];
          for (int k = 0; k < 3; k++) acc += qprod(v[k], model_mat[i * 4 + k]);
          res[i] = clip32(acc);
        end
        p = '{res[0], res[1], res[2]};
        return 1'b1;
      end
      default: begin
        foreach (stp[i]) stp[i] = (i % 5 == 0) ? longint'(ONE) : 0;
        if (c.kind == KIND_ROTATE) begin
          if (c.axis == AXIS_NONE) return 1'b0;
          // angles wrap at a full turn; fold into the first quadrant
          a = int'(c.angle) % TURN;
          r = a % QUARTER;
          case (quad_t'(a / QUARTER))
            QUAD_0: begin sn = sin_rom[r];  cs = cos_rom[r];  end
            QUAD_1: begin sn = cos_rom[r];  cs = -sin_rom[r]; end
            QUAD_2: begin sn = -sin_rom[r]; cs = -cos_rom[r]; end
            default: begin sn = -cos_rom[r]; cs = sin_rom[r]; end
          endcase
          // axis x rotates y-z, axis y z-x, axis z x-y
          m1 = int'(c.axis) % 3;
          m2 = (m1 + 1) % 3;
          stp[m1 * 4 + m1] = cs;
          stp[m1 * 4 + m2] = sn;
          stp[m2 * 4 + m2] = cs;
          stp[m2 * 4 + m1] = -sn;
        end else begin
          stp[3]  = v[0];
          stp[7]  = v[1];
          stp[11] = v[2];
        end
        // premultiply: new = step * current, bottom rows 0,0,0,1 implied
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 4; j++) begin
            acc = (j == 3) ? stp[i * 4 + 3] : 0;
            for (int k = 0; k < 3; k++) acc += qprod(stp[i * 4 + k], model_mat[k * 4 + j]);
            nm[i * 4 + j] = clip32(acc);
          end
        end
        model_mat = nm;
        return 1'b0;
      end
    endcase
  endfunction

  // Build the quarter-wave sine and cosine table: Taylor series in unsigned
  // Q2.62, then round to nearest at the Q16.16 point.
  initial begin : sine_table
    bit [63:0] step, x, x2, st, ss, ct, cc, div_s, div_c, kk;
    step = PI_Q62 / (180 * STEPS);
    for (int r = 0; r < QUARTER; r++) begin
      x  = r * step;
      x2 = q62_mul(x, x);
      st = x;
      ss = x;
      ct = Q62_ONE;
      cc = Q62_ONE;
      for (int k = 1; k < 40; k++) begin
        kk    = k;
        div_s = (2 * kk) * (2 * kk + 1);
        div_c = (2 * kk - 1) * (2 * kk);
        st    = q62_mul(st, x2) / div_s;
        ct    = q62_mul(ct, x2) / div_c;
        if (k % 2 == 1) begin
          ss -= st;
          cc -= ct;
        end else begin
          ss += st;
          cc += ct;
        end
        if (st == 0 && ct == 0) break;
      end
      sin_rom[r] = longint'((ss + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
      cos_rom[r] = longint'((cc + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Coordinates: full 32-bit noise, mid-range, tiny values, and the rails.
  function automatic coord_t pick_coord();
    int v;
    case ($urandom_range(0, 4))
      0, 1: return coord_t'($urandom());
      2: begin
        v = $urandom_range(0, 32'h00FF_FFFF);
        return coord_t'(v - 32'h0080_0000);
      end
      3: begin
        v = $urandom_range(0, 32'h0007_FFFF);
        return coord_t'(v - 32'h0004_0000);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return coord_t'(-1);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Offer one command, hold it through any stall, then predict its result
  // at the transfer edge. A typed expectation, if given, replaces the predicted one.
  task automatic offer(input cmd_t c, input bit typed, input point_t want);
    point_t predicted;
    if (bursty && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    kind        <= c.kind;
    axis_select <= c.axis;
    angle       <= c.angle;
    coord_x     <= c.x;
    coord_y     <= c.y;
    coord_z     <= c.z;
    cmd_valid   <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    if (apply_command(c, predicted)) awaited_points.push_back(typed ? want : predicted);
  endtask

  initial begin : driver
    cmd_t   c;
    row_t   row;
    point_t none;
    int     pick;
    none = '0;
    // the matrix comes out of reset as identity
    void'(apply_command('{KIND_IDENTITY, AXIS_NONE, '0, '0, '0, '0}, none));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (DIRECTED[n]) begin
      row = DIRECTED[n];
      c   = '{row.kind, row.axis, row.angle, row.x, row.y, row.z};
      offer(c, row.typed, '{row.ex, row.ey, row.ez});
    end

    // Random commands. Identity is rare so that rotations and offsets build
    // up long chains; idling is on, then off for a stretch, then on again,
    // and off for the last part of the run.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      bursty = !(n >= 600 && n < 800) && n < 1200;
      if (n == 300) hold_request = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 5)       c.kind = KIND_IDENTITY;
      else if (pick < 35) c.kind = KIND_ROTATE;
      else if (pick < 55) c.kind = KIND_TRANSLATE;
      else                c.kind = KIND_POINT;
      c.axis  = axis_t'($urandom_range(0, 3));
      c.angle = ANGLE_W'($urandom_range(0, 8191));
      c.x     = pick_coord();
      c.y     = pick_coord();
      c.z     = pick_coord();
      offer(c, 1'b0, none);
    end
    cmd_valid <= 1'b0;

    // Drain: wait for every outstanding point, then keep watching to
    // catch any stray result.
    while (awaited_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_points.size() == 0)
      $display("affine_transform_engine_test: done, clean");
    else
      $display("affine_transform_engine_test: done, errors");
    $finish;
  end

  // Receiver: random stall bursts while bursty is set, one long hold-off on
  // request so the pipeline fills and pushes back on the command side.
  initial begin : receiver
    wait (!rst);
    forever begin
      if (hold_request) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (bursty && $urandom_range(0, 3) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        res_stall <= 1'b0;
        repeat (bursty ? $urandom_range(1, 8) : 1) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: MISMATCH %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input coord_t got, input coord_t want);
    if (got !== want)
      note_mismatch($sformatf("%s expected %h (%0d), got %h (%0d)",
                              name, want, want, got, got));
  endtask

  // Compare each result transfer against the oldest outstanding point.
  always @(posedge clk) begin : result_check
    point_t want;
    if (!rst && res_valid && !res_stall) begin
      if (awaited_points.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h %h %h", out_x, out_y, out_z));
      end else begin
        want = awaited_points.pop_front();
        check_field("out_x", out_x, want.x);
        check_field("out_y", out_y, want.y);
        check_field("out_z", out_z, want.z);
      end
    end
  end

  // Hard stop if the block hangs.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("affine_transform_engine_test: done, errors");
    $finish;
  end

endmodule

[affine_transform_engine.f]
+incdir+hdl
hdl/afe_pkg.sv
hdl/affine_transform_engine.sv
hdl/afe_checker.sv
tb/affine_transform_engine_test.sv
